// ===== hdl/swdb_pkg.sv =====
`timescale 1ns / 1ps

package swdb_pkg;

  localparam int unsigned IDX_W   = 3;
  localparam int unsigned HIST_W  = 8;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned CFG_W   = 8;

  typedef logic [1:0]        event_t;
  typedef logic [1:0]        cfg_idx_t;
  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [MASK_W-1:0] mask_t;

  // register map
  localparam cfg_idx_t CFG_TIMER_MODE  = 2'd0;
  localparam cfg_idx_t CFG_ACTIVE_HIGH = 2'd1;
  localparam cfg_idx_t CFG_SHORT_TICKS = 2'd2;
  localparam cfg_idx_t CFG_LONG_TICKS  = 2'd3;

  localparam mask_t RST_TIMER_MODE  = 4'h0;
  localparam mask_t RST_ACTIVE_HIGH = 4'h0;
  localparam hist_t RST_SHORT_TICKS = 8'd10;
  localparam hist_t RST_LONG_TICKS  = 8'd100;

  localparam hist_t HIST_MAX = 8'hFF;

  // event codes, debounce mode
  localparam event_t EV_NONE = 2'd0;
  localparam event_t EV_ON   = 2'd1;
  localparam event_t EV_OFF  = 2'd2;
  // event codes, timer mode
  localparam event_t EV_SHORT_PRESS   = 2'd1;
  localparam event_t EV_LONG_REACHED  = 2'd2;
  localparam event_t EV_SHORT_REACHED = 2'd3;

endpackage

// ===== hdl/switch_debounce_press_timer_core.sv =====
`timescale 1ns / 1ps

// Switch debouncer and press timer. Each request on the input channel is one
// evaluation tick for one switch (switch number plus raw pin level) and gives
// exactly one event code on the output channel, in order. A switch in debounce
// mode shifts its on-samples into an 8-bit history and reports on/off once the
// history shows HIST_BITS stable samples after a change; a switch in timer
// mode counts on-ticks (saturating at 255), reports reaching the short and
// long thresholds, and on release reports a short press if the hold lay above
// short but not above long. Switch numbers of NUM_SWITCHES or more give no
// event and touch no state. One request per clock is taken while the result
// channel is not stalled; each request passes the input register, then the
// per-switch read-modify-write into the result register. Consecutive
// ticks on the same switch need no spacing since the history is updated in
// the same edge that registers the result. Configuration may only be written
// while the block holds no request.
module switch_debounce_press_timer_core
  import swdb_pkg::*;
#(
  parameter int unsigned NUM_SWITCHES = 4,
  parameter int unsigned HIST_BITS    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IDX_W-1:0] in_switch_index,
  input  logic             in_pin_level,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output event_t           out_event_code,
  // configuration
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [HIST_BITS:0] PAT_ON  = {1'b0, {HIST_BITS{1'b1}}};
  localparam logic [HIST_BITS:0] PAT_OFF = {{HIST_BITS{1'b1}}, 1'b0};

  // configuration registers
  mask_t timer_mode_r;
  mask_t active_high_r;
  hist_t short_ticks_r;
  hist_t long_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_mode_r  <= RST_TIMER_MODE;
      active_high_r <= RST_ACTIVE_HIGH;
      short_ticks_r <= RST_SHORT_TICKS;
      long_ticks_r  <= RST_LONG_TICKS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TIMER_MODE:  timer_mode_r  <= cfg_wdata[MASK_W-1:0];
        CFG_ACTIVE_HIGH: active_high_r <= cfg_wdata[MASK_W-1:0];
        CFG_SHORT_TICKS: short_ticks_r <= cfg_wdata;
        CFG_LONG_TICKS:  long_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register stage
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_pin_r;
  logic             s1_adv;      // stage 1 moves into the result register
  logic             in_take;

  // result register
  logic   out_vld_r;
  event_t out_ev_r;
  event_t ev_nxt;

  // out register can load when empty or being drained this cycle
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_idx_r <= in_switch_index;
      s1_pin_r <= in_pin_level;
    end
  end

  // per-switch store: history in debounce mode, tick count in timer mode
  hist_t hist_r [NUM_SWITCHES];
  hist_t hist_sel;
  hist_t hist_nxt;
  logic  in_range;
  logic  sw_is_tmr;
  logic  sw_act_hi;
  logic  sw_on;

  always_comb begin
    hist_sel = '0;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (s1_idx_r == IDX_W'(i)) begin
        hist_sel = hist_r[i];
      end
    end
  end

  assign in_range = ({1'b0, s1_idx_r} < (IDX_W + 1)'(NUM_SWITCHES));

  // masks cover switches 0..3 only; higher switches read as zero
  assign sw_is_tmr = !s1_idx_r[IDX_W-1] && timer_mode_r[s1_idx_r[1:0]];
  assign sw_act_hi = !s1_idx_r[IDX_W-1] && active_high_r[s1_idx_r[1:0]];
  assign sw_on     = sw_act_hi ? s1_pin_r : !s1_pin_r;

  hist_t shifted;
  hist_t cnt_inc;

  assign shifted = {hist_sel[HIST_W-2:0], sw_on};
  assign cnt_inc = (hist_sel == HIST_MAX) ? hist_sel : hist_sel + hist_t'(1);

  always_comb begin
    ev_nxt   = EV_NONE;
    hist_nxt = hist_sel;
    if (!in_range) begin
      ev_nxt = EV_NONE;
    end else if (sw_is_tmr) begin
      if (sw_on) begin
        hist_nxt = cnt_inc;
        // long wins when both thresholds match
        priority if (cnt_inc == long_ticks_r) begin
          ev_nxt = EV_LONG_REACHED;
        end else if (cnt_inc == short_ticks_r) begin
          ev_nxt = EV_SHORT_REACHED;
        end else begin
          ev_nxt = EV_NONE;
        end
      end else begin
        hist_nxt = '0;
        // held past long: release is silent
        priority if (hist_sel > long_ticks_r) begin
          ev_nxt = EV_NONE;
        end else if (hist_sel > short_ticks_r) begin
          ev_nxt = EV_SHORT_PRESS;
        end else begin
          ev_nxt = EV_NONE;
        end
      end
    end else begin
      hist_nxt = shifted;
      priority if (shifted[HIST_BITS:0] == PAT_ON) begin
        ev_nxt = EV_ON;
      end else if (shifted[HIST_BITS:0] == PAT_OFF) begin
        ev_nxt = EV_OFF;
      end else begin
        ev_nxt = EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (!rst_n) begin
        hist_r[i] <= '0;
      end else if (s1_adv && in_range && (s1_idx_r == IDX_W'(i))) begin
        hist_r[i] <= hist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ev_r <= ev_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_code = out_ev_r;

endmodule

// ===== hdl/swdb_checker.sv =====
`timescale 1ns / 1ps

module swdb_checker
  import swdb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input event_t           out_event_code,
  input logic             cfg_wr_en,
  input cfg_idx_t         cfg_index,
  input logic [CFG_W-1:0] cfg_wdata
);

  // shadow of the timer mode mask, seen from the config port
  mask_t tmask_r;
  mask_t tmask_nxt;

  assign tmask_nxt = (cfg_wr_en && (cfg_index == CFG_TIMER_MODE)) ?
                     cfg_wdata[MASK_W-1:0] : tmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmask_r <= RST_TIMER_MODE;
    end else begin
      tmask_r <= tmask_nxt;
    end
  end

  // no result straight out of reset
  a_rst_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid in the cycle after reset");

  // input side only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with result side free");

  // a held result keeps its code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_code)))
    else $error("stalled result changed or dropped");

  // short-reached only exists in timer mode
  a_timer_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_code == EV_SHORT_REACHED)) |-> (tmask_r != '0))
    else $error("timer event with no switch in timer mode");

endmodule

bind switch_debounce_press_timer_core swdb_checker u_swdb_checker (.*);

// ===== verif/switch_debounce_press_timer_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the switch debouncer / press timer.
// A short table of hand-picked requests runs first. After it come phases of
// random requests, each phase under fresh register settings. Every accepted
// request is run through a local model of the per-switch store, and the
// event it should give is queued. The output monitor compares each accepted
// event against the head of that queue.
module switch_debounce_press_timer_core_tb;
  import swdb_pkg::*;

  localparam int unsigned NUM_SW    = 4;
  localparam int unsigned HB        = 3;
  localparam int unsigned N_PHASES  = 12;
  localparam int unsigned SAT_PHASE = 4;   // phase that holds one switch into saturation
  localparam int unsigned CALM_FROM = 10;  // phases from here on run with no idling

  typedef struct {
    logic             is_cfg;
    mask_t            tm;
    mask_t            ah;
    hist_t            st;
    hist_t            lt;
    logic [IDX_W-1:0] sw;
    logic             pin;
    logic             typed;   // row carries a hand-written expected event
    event_t           ev;
  } stim_row_t;

  typedef struct {
    event_t           ev;
    logic [IDX_W-1:0] sw;
    logic             pin;
  } due_t;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [IDX_W-1:0] in_switch_index = '0;
  logic             in_pin_level    = 1'b0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  event_t           out_event_code;
  logic             cfg_wr_en       = 1'b0;
  cfg_idx_t         cfg_index       = CFG_TIMER_MODE;
  logic [CFG_W-1:0] cfg_wdata       = '0;

  // mirror of the block's registers and per-switch stores
  mask_t mode_r     = RST_TIMER_MODE;
  mask_t polarity_r = RST_ACTIVE_HIGH;
  hist_t short_r    = RST_SHORT_TICKS;
  hist_t long_r     = RST_LONG_TICKS;
  hist_t sw_store [NUM_SW];

  due_t events_due [$];
  stim_row_t dir_tab [$];

  int  mismatches  = 0;
  int  ticks_sent  = 0;
  int  events_seen = 0;
  int  reg_sets    = 0;
  bit  idle_on     = 1'b0;  // random gaps on both sides when set
  int  stall_left  = 0;

  switch_debounce_press_timer_core #(
    .NUM_SWITCHES (NUM_SW),
    .HIST_BITS    (HB)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_switch_index (in_switch_index),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("switch_debounce_press_timer_core_tb: done, errors");
    $finish;
  end

  // Event for one tick; updates the mirrored store as the block would.
  function automatic event_t next_event(input logic [IDX_W-1:0] sw, input logic pin);
    hist_t  c;
    logic   on;
    event_t ev;
    ev = EV_NONE;
    if (sw >= NUM_SW) return EV_NONE;   // unbuilt switch: no event, no state touched
    on = polarity_r[sw] ? pin : ~pin;
    c  = sw_store[sw];
    if (mode_r[sw]) begin
      if (on) begin
        if (c != HIST_MAX) c = c + hist_t'(1);
        sw_store[sw] = c;
        // long check first, so it wins on equal thresholds
        if (c == long_r) ev = EV_LONG_REACHED;
        else if (c == short_r) ev = EV_SHORT_REACHED;
      end else begin
        // held past long: release is silent
        if (c > long_r) ev = EV_NONE;
        else if (c > short_r) ev = EV_SHORT_PRESS;
        sw_store[sw] = '0;
      end
    end else begin
      c = {c[HIST_W-2:0], on};
      sw_store[sw] = c;
      if (c[HB:0] == {1'b0, {HB{1'b1}}}) ev = EV_ON;
      else if (c[HB:0] == {{HB{1'b1}}, 1'b0}) ev = EV_OFF;
    end
    return ev;
  endfunction

  function automatic stim_row_t tick_row(input logic [IDX_W-1:0] sw, input logic pin,
                                         input logic typed, input event_t ev);
    stim_row_t r;
    r = '{default: '0};
    r.sw    = sw;
    r.pin   = pin;
    r.typed = typed;
    r.ev    = ev;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input mask_t tm, input mask_t ah,
                                        input hist_t st, input hist_t lt);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.tm     = tm;
    r.ah     = ah;
    r.st     = st;
    r.lt     = lt;
    return r;
  endfunction

  // Registers only move once the block has drained every request.
  task automatic write_regs(input mask_t tm, input mask_t ah, input hist_t st, input hist_t lt);
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TIMER_MODE;
    cfg_wdata <= {4'b0, tm};
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_HIGH;
    cfg_wdata <= {4'b0, ah};
    @(posedge clk);
    cfg_index <= CFG_SHORT_TICKS;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_index <= CFG_LONG_TICKS;
    cfg_wdata <= lt;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    mode_r     = tm;
    polarity_r = ah;
    short_r    = st;
    long_r     = lt;
    reg_sets++;
  endtask

  // One request; the expected event is queued at the edge it is taken.
  task automatic send_tick(input logic [IDX_W-1:0] sw, input logic pin,
                           input logic typed, input event_t typed_ev);
    event_t ev;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_switch_index <= sw;
    in_pin_level    <= pin;
    @(posedge clk);
    while (!(in_valid === 1'b1 && in_stall === 1'b0)) @(posedge clk);
    ev = next_event(sw, pin);
    if (typed) ev = typed_ev;
    events_due.push_back('{ev: ev, sw: sw, pin: pin});
    ticks_sent++;
  endtask

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    due_t d;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (events_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event, expected none, actual %0d", $time, out_event_code);
      end else begin
        d = events_due.pop_front();
        if (out_event_code !== d.ev) begin
          mismatches++;
          $display("%0t: event mismatch sw %0d pin %0b: expected %0d actual %0d",
                   $time, d.sw, d.pin, d.ev, out_event_code);
        end else if (d.ev != EV_NONE) begin
          events_seen++;
        end
      end
    end
  end

  initial begin
    stim_row_t        r;
    mask_t            tm;
    mask_t            ah;
    hist_t            st;
    hist_t            lt;
    logic [IDX_W-1:0] sw;
    logic             on;
    logic             pin;
    int               budget;
    int               n;
    int               len;
    int               kind;

    foreach (sw_store[i]) sw_store[i] = '0;

    // Reset defaults: every switch debounced, pins active low.
    dir_tab.push_back(tick_row(3'd0, 1'b0, 1'b1, EV_NONE));
    dir_tab.push_back(tick_row(3'd0, 1'b0, 1'b1, EV_NONE));
    dir_tab.push_back(tick_row(3'd0, 1'b0, 1'b1, EV_ON));
    dir_tab.push_back(tick_row(3'd0, 1'b1, 1'b1, EV_OFF));
    // switch numbers past the built count
    dir_tab.push_back(tick_row(3'd7, 1'b0, 1'b1, EV_NONE));
    dir_tab.push_back(tick_row(3'd4, 1'b1, 1'b1, EV_NONE));
    dir_tab.push_back(tick_row(3'd0, 1'b0, 1'b0, EV_NONE));
    // timer mode on all; switch 0 keeps its debounce history as a count
    dir_tab.push_back(cfg_row(4'hF, 4'hF, 8'd2, 8'd3));
    dir_tab.push_back(tick_row(3'd0, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd0, 1'b0, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd1, 1'b1, 1'b1, EV_NONE));
    dir_tab.push_back(tick_row(3'd1, 1'b1, 1'b1, EV_SHORT_REACHED));
    dir_tab.push_back(tick_row(3'd1, 1'b1, 1'b1, EV_LONG_REACHED));
    dir_tab.push_back(tick_row(3'd1, 1'b0, 1'b1, EV_SHORT_PRESS));
    // held past long, release says nothing
    dir_tab.push_back(tick_row(3'd2, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd2, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd2, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd2, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd2, 1'b0, 1'b0, EV_NONE));
    // zero thresholds, mixed modes and polarities
    dir_tab.push_back(cfg_row(4'b1010, 4'b0101, 8'd0, 8'd0));
    dir_tab.push_back(tick_row(3'd1, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd1, 1'b0, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd1, 1'b1, 1'b0, EV_NONE));
    // equal thresholds: long wins
    dir_tab.push_back(cfg_row(4'hF, 4'hF, 8'd1, 8'd1));
    dir_tab.push_back(tick_row(3'd3, 1'b1, 1'b1, EV_LONG_REACHED));
    dir_tab.push_back(tick_row(3'd3, 1'b0, 1'b0, EV_NONE));
    dir_tab.push_back(cfg_row(4'h0, 4'hF, 8'd255, 8'd255));
    dir_tab.push_back(tick_row(3'd3, 1'b1, 1'b0, EV_NONE));
    dir_tab.push_back(tick_row(3'd3, 1'b1, 1'b0, EV_NONE));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.is_cfg) write_regs(r.tm, r.ah, r.st, r.lt);
      else send_tick(r.sw, r.pin, r.typed, r.ev);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // extremes first, then random settings with mostly small thresholds
      case (ph)
        0: begin
          tm = 4'h0; ah = 4'hF; st = 8'd0;   lt = 8'd255;
        end
        1: begin
          tm = 4'hF; ah = 4'h0; st = 8'd255; lt = 8'd0;
        end
        SAT_PHASE: begin
          tm = 4'hF; ah = 4'hF; st = 8'd254; lt = 8'd255;
        end
        default: begin
          tm = mask_t'($urandom_range(0, 15));
          ah = mask_t'($urandom_range(0, 15));
          st = hist_t'($urandom_range(0, 12));
          lt = hist_t'($urandom_range(0, 30));
          if ($urandom_range(0, 5) == 0) st = hist_t'($urandom_range(0, 255));
          if ($urandom_range(0, 5) == 0) lt = hist_t'($urandom_range(0, 255));
        end
      endcase
      write_regs(tm, ah, st, lt);
      idle_on = (ph < CALM_FROM) && ($urandom_range(0, 3) != 0);

      if (ph == SAT_PHASE) begin
        // hold well past 255 so the count saturates, then let go
        sw = 3'($urandom_range(0, NUM_SW - 1));
        repeat (258) send_tick(sw, 1'b1, 1'b0, EV_NONE);
        send_tick(sw, 1'b0, 1'b0, EV_NONE);
      end

      budget = 6;
      n = 0;
      while (n < budget) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // press-hold-release on one built switch, with the odd bounce
          sw  = 3'($urandom_range(0, NUM_SW - 1));
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (lt > 36) ? 40 : lt + 4)
                                             : $urandom_range(1, 12);
          for (int k = 0; k < len + $urandom_range(1, 6); k++) begin
            on  = (k < len);
            if ($urandom_range(0, 11) == 0) on = ~on;
            pin = polarity_r[sw[1:0]] ? on : ~on;
            send_tick(sw, pin, 1'b0, EV_NONE);
            n++;
          end
        end else if (kind < 9) begin
          send_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0, EV_NONE);
          n++;
        end else begin
          repeat ($urandom_range(1, 4))
            send_tick(3'($urandom_range(NUM_SW, 7)), 1'($urandom_range(0, 1)), 1'b0, EV_NONE);
        end
      end
    end

    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("switch_debounce_press_timer_core_tb: %0d ticks over %0d register settings",
             ticks_sent, reg_sets);
    $display("switch_debounce_press_timer_core_tb: %0d non-idle events matched, %0d mismatches",
             events_seen, mismatches);
    if (mismatches == 0) begin
      $display("switch_debounce_press_timer_core_tb: done, clean");
    end else begin
      $display("switch_debounce_press_timer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
